[design/htlp_pkg.sv]
// shared types and codes of the linear probing hash table
`default_nettype none

package htlp_pkg;

   localparam int KEY_FIELD_W  = 16;
   localparam int SLOT_FIELD_W = 4;
   localparam int STEP_BITS    = 4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_PRESENT  = 2'd1;
   localparam logic [1:0] ST_ABSENT   = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic                   cmd;
      logic [KEY_FIELD_W-1:0] key;
   } htlp_req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [SLOT_FIELD_W-1:0] slot;
   } htlp_rsp_type;

endpackage

`default_nettype wire

[design/htlp_rem_step.sv]
// shared remainder unit: folds one digit of a dividend into a running remainder
`default_nettype none

module htlp_rem_step #(
   parameter int RW = 4
) (
   input  wire logic [RW-1:0]                rem_in_val,
   input  wire logic [htlp_pkg::STEP_BITS-1:0] digit,
   input  wire logic [RW:0]                  divisor,
   output logic      [RW-1:0]                rem_out_val
);
   import htlp_pkg::*;

   logic [RW:0] part;

   always_comb begin
      part = {1'b0, rem_in_val};
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         part = {part[RW-1:0], digit[i]};
         if (part >= divisor) begin
            part = part - divisor;
         end
      end
      rem_out_val = part[RW-1:0];
   end

endmodule

`default_nettype wire

[design/htlp_table.sv]
// slot memory: valid mark and key per slot, one write and one registered read port
`default_nettype none

module htlp_table #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 17
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data_ff
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[design/hash_table_linear_probe.sv]
// top level: sequencer of the linear probing hash table
//
//  channel   ports                          handshake
//  request   start, busy, req_data          taken when start high and busy low
//  response  rsp_strobe, rsp_data           one cycle pulse, cannot be held off
//
// after reset a clearing pass empties the slots one by one, busy high
// an item is reduced a digit at a time in the shared remainder unit, first the key
// modulo HASH_PRIME, then that remainder modulo TABLE_SLOTS, before probing the
// memory, one slot a cycle through its registered read port
// the response strobe is registered, rising in the cycle after the deciding
// probe check; busy drops with it
`default_nettype none

module hash_table_linear_probe #(
   parameter int TABLE_SLOTS = 16,
   parameter int HASH_PRIME  = 13,
   parameter int KEY_BITS    = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire htlp_pkg::htlp_req_type req_data,
   output logic                        rsp_strobe,
   output htlp_pkg::htlp_rsp_type      rsp_data
);
   import htlp_pkg::*;

   localparam int KW      = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
   localparam int SW      = $clog2(TABLE_SLOTS);
   localparam int CW      = $clog2(TABLE_SLOTS + 1);
   localparam int DMAX    = (HASH_PRIME > TABLE_SLOTS) ? HASH_PRIME : TABLE_SLOTS;
   localparam int RW      = $clog2(DMAX);
   localparam int PB      = $clog2(HASH_PRIME);
   localparam int NDIG1   = (KW + STEP_BITS - 1) / STEP_BITS;
   localparam int NDIG2   = (PB + STEP_BITS - 1) / STEP_BITS;
   localparam int NDIGMAX = (NDIG1 > NDIG2) ? NDIG1 : NDIG2;
   localparam int SRCW    = NDIGMAX * STEP_BITS;
   localparam int DCW     = $clog2(NDIGMAX + 1);
   localparam int MW      = KW + 1;

   localparam logic [RW:0] PRIME_D = (RW + 1)'(HASH_PRIME);
   localparam logic [RW:0] SLOTS_D = (RW + 1)'(TABLE_SLOTS);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_FOLD,
      S_PROBE
   } state_type;

   state_type    state_ff, state_in;
   logic         cmd_ff, cmd_in;
   logic [KW-1:0] key_ff, key_in;
   logic [SRCW-1:0] src_ff, src_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [DCW-1:0] dig_ff, dig_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic [CW-1:0] issued_ff, issued_in;
   logic         chk_ff, chk_in;
   logic [SW-1:0] chk_slot_ff, chk_slot_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic         rsp_strobe_ff, rsp_strobe_in;
   htlp_rsp_type rsp_ff, rsp_in;

   logic [RW:0]   divisor;
   logic [RW-1:0] rem_next;
   logic          wr_en;
   logic [SW-1:0] wr_addr;
   logic [MW-1:0] wr_data;
   logic [MW-1:0] rd_data;

   assign divisor = (state_ff == S_FOLD) ? SLOTS_D : PRIME_D;

   htlp_rem_step #(
      .RW(RW)
   ) u_rem (
      .rem_in_val  (rem_ff),
      .digit       (src_ff[SRCW-1 -: STEP_BITS]),
      .divisor     (divisor),
      .rem_out_val (rem_next)
   );

   htlp_table #(
      .DEPTH(TABLE_SLOTS),
      .AW   (SW),
      .DW   (MW)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (cur_ff),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      src_in        = src_ff;
      rem_in        = rem_ff;
      dig_in        = dig_ff;
      cur_in        = cur_ff;
      issued_in     = issued_ff;
      chk_in        = chk_ff;
      chk_slot_in   = chk_slot_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_slot_ff;
      wr_data       = {1'b1, key_ff};

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + SW'(1);
            if (clr_ff == SW'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_data.cmd;
               key_in   = req_data.key[KW-1:0];
               src_in   = SRCW'(req_data.key[KW-1:0]) << (SRCW - NDIG1 * STEP_BITS);
               rem_in   = '0;
               dig_in   = '0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            rem_in = rem_next;
            src_in = src_ff << STEP_BITS;
            dig_in = dig_ff + DCW'(1);
            if (dig_ff == DCW'(NDIG1 - 1)) begin
               src_in   = SRCW'(rem_next) << (SRCW - NDIG2 * STEP_BITS);
               rem_in   = '0;
               dig_in   = '0;
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            rem_in = rem_next;
            src_in = src_ff << STEP_BITS;
            dig_in = dig_ff + DCW'(1);
            if (dig_ff == DCW'(NDIG2 - 1)) begin
               cur_in    = rem_next[SW-1:0];
               issued_in = '0;
               chk_in    = 1'b0;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            // issue the next read while checking the previous one
            if (issued_ff != CW'(TABLE_SLOTS)) begin
               chk_in      = 1'b1;
               chk_slot_in = cur_ff;
               cur_in      = (cur_ff == SW'(TABLE_SLOTS - 1)) ? '0 : cur_ff + SW'(1);
               issued_in   = issued_ff + CW'(1);
            end else begin
               chk_in = 1'b0;
            end
            if (chk_ff) begin
               if (!rd_data[MW-1]) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
                  if (cmd_ff == CMD_SEARCH) begin
                     rsp_in.status = ST_ABSENT;
                     rsp_in.slot   = '0;
                  end else begin
                     wr_en         = 1'b1;
                     rsp_in.status = ST_INSERTED;
                     rsp_in.slot   = SLOT_FIELD_W'(chk_slot_ff);
                  end
               end else if (rd_data[KW-1:0] == key_ff) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
                  rsp_in.status = ST_PRESENT;
                  rsp_in.slot   = SLOT_FIELD_W'(chk_slot_ff);
               end else if (issued_ff == CW'(TABLE_SLOTS)) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
                  rsp_in.status = (cmd_ff == CMD_SEARCH) ? ST_ABSENT : ST_FULL;
                  rsp_in.slot   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         chk_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         chk_ff        <= chk_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      src_ff      <= src_in;
      rem_ff      <= rem_in;
      dig_ff      <= dig_in;
      cur_ff      <= cur_in;
      issued_ff   <= issued_in;
      chk_slot_ff <= chk_slot_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

[bench/hash_table_linear_probe_tb.sv]
// testbench of the linear probing hash table: directed and random items checked against a predictor
`default_nettype none

module hash_table_linear_probe_tb;
   import htlp_pkg::*;

   localparam int SLOTS      = 16;
   localparam int PRIME      = 13;
   localparam int RAND_ITEMS = 1300;
   localparam int MAX_GAP    = 18;
   localparam int DRAIN      = 30;
   localparam int LIMIT      = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   htlp_req_type req_data = '0;
   logic         busy;
   logic         rsp_strobe;
   htlp_rsp_type rsp_data;

   htlp_req_type pending_items[$];
   htlp_rsp_type expected_answers[$];
   logic [KEY_FIELD_W-1:0] issued_keys[$];

   logic                   table_valid[SLOTS];
   logic [KEY_FIELD_W-1:0] table_keys[SLOTS];

   int errors = 0;
   int taken  = 0;
   int wait_left = 0;
   int cycles = 0;

   hash_table_linear_probe #(
      .TABLE_SLOTS(SLOTS),
      .HASH_PRIME(PRIME),
      .KEY_BITS(KEY_FIELD_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // walk the table from the home slot and update it as the block would
   function automatic htlp_rsp_type probe_table(htlp_req_type item);
      htlp_rsp_type answer;
      int home;
      int s;
      logic done;
      home = (int'(item.key) % PRIME) % SLOTS;
      answer.status = (item.cmd == CMD_SEARCH) ? ST_ABSENT : ST_FULL;
      answer.slot = '0;
      done = 1'b0;
      for (int off = 0; off < SLOTS; off++) begin
         s = (home + off) % SLOTS;
         if (!done) begin
            if (!table_valid[s]) begin
               if (item.cmd == CMD_INSERT) begin
                  table_valid[s] = 1'b1;
                  table_keys[s] = item.key;
                  answer.status = ST_INSERTED;
                  answer.slot = SLOT_FIELD_W'(s);
               end
               done = 1'b1;
            end else if (table_keys[s] == item.key) begin
               answer.status = ST_PRESENT;
               answer.slot = SLOT_FIELD_W'(s);
               done = 1'b1;
            end
         end
      end
      return answer;
   endfunction

   function automatic void add_item(logic cmd, logic [KEY_FIELD_W-1:0] key);
      htlp_req_type item;
      item.cmd = cmd;
      item.key = key;
      pending_items.push_back(item);
      if (cmd == CMD_INSERT) issued_keys.push_back(key);
   endfunction

   function automatic logic [KEY_FIELD_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6 && issued_keys.size() > 0)
         return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
      else if (sel < 8)
         return KEY_FIELD_W'(PRIME * $urandom_range(0, 5000) + $urandom_range(0, PRIME - 1));
      else
         return KEY_FIELD_W'($urandom);
   endfunction

   // driver
   always @(posedge clock) begin
      logic launch;
      if (reset) begin
         start <= 1'b0;
         wait_left = 0;
      end else begin
         launch = start;
         if (start && !busy) begin
            expected_answers.push_back(probe_table(req_data));
            taken++;
            launch = 1'b0;
            if ((taken / 64) % 3 == 0)
               wait_left = 0;
            else
               wait_left = $urandom_range(0, MAX_GAP);
         end
         if (!launch) begin
            if (wait_left > 0)
               wait_left--;
            else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               launch = 1'b1;
            end
         end
         start <= launch;
      end
   end

   // monitor
   always @(posedge clock) begin
      htlp_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected item: status %0d slot %0d", rsp_data.status, rsp_data.slot);
            errors++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.slot !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_data.slot);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         table_valid[i] = 1'b0;
         table_keys[i] = '0;
      end

      add_item(CMD_SEARCH, 16'd0);
      add_item(CMD_INSERT, 16'd0);
      add_item(CMD_INSERT, 16'hffff);
      add_item(CMD_INSERT, 16'd12);
      add_item(CMD_INSERT, 16'd12);
      add_item(CMD_INSERT, 16'd25);
      add_item(CMD_INSERT, 16'd38);
      add_item(CMD_INSERT, 16'd51);
      add_item(CMD_INSERT, 16'd64);
      add_item(CMD_SEARCH, 16'd64);
      add_item(CMD_SEARCH, 16'd77);
      add_item(CMD_SEARCH, 16'hffff);
      add_item(CMD_INSERT, 16'hffff);
      for (int k = 3; k <= 11; k++) add_item(CMD_INSERT, KEY_FIELD_W'(k));
      add_item(CMD_INSERT, 16'd13);
      add_item(CMD_SEARCH, 16'd1000);
      add_item(CMD_SEARCH, 16'd0);

      for (int n = 0; n < RAND_ITEMS; n++)
         add_item(($urandom_range(0, 1) == 1) ? CMD_SEARCH : CMD_INSERT, pick_key());

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0 || start || expected_answers.size() > 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
design/htlp_pkg.sv
design/htlp_rem_step.sv
design/htlp_table.sv
design/hash_table_linear_probe.sv
bench/hash_table_linear_probe_tb.sv
